// ----- sv/jiab_pkg.sv -----
// Shared types, operation codes and helpers for the JVM integer ALU/branch unit.
// No dependencies; every other file in sv/ uses this package.
`default_nettype none

package jiab_pkg;

  localparam int PC_BITS   = 16;
  localparam int DIV_STEPS = 64;

  localparam logic [5:0] OP_IADD  = 6'd0;
  localparam logic [5:0] OP_LADD  = 6'd1;
  localparam logic [5:0] OP_ISUB  = 6'd2;
  localparam logic [5:0] OP_LSUB  = 6'd3;
  localparam logic [5:0] OP_IMUL  = 6'd4;
  localparam logic [5:0] OP_LMUL  = 6'd5;
  localparam logic [5:0] OP_IDIV  = 6'd6;
  localparam logic [5:0] OP_LDIV  = 6'd7;
  localparam logic [5:0] OP_IREM  = 6'd8;
  localparam logic [5:0] OP_LREM  = 6'd9;
  localparam logic [5:0] OP_ISHL  = 6'd10;
  localparam logic [5:0] OP_LSHL  = 6'd11;
  localparam logic [5:0] OP_ISHR  = 6'd12;
  localparam logic [5:0] OP_LSHR  = 6'd13;
  localparam logic [5:0] OP_IUSHR = 6'd14;
  localparam logic [5:0] OP_LUSHR = 6'd15;
  localparam logic [5:0] OP_IAND  = 6'd16;
  localparam logic [5:0] OP_LAND  = 6'd17;
  localparam logic [5:0] OP_IOR   = 6'd18;
  localparam logic [5:0] OP_LOR   = 6'd19;
  localparam logic [5:0] OP_IXOR  = 6'd20;
  localparam logic [5:0] OP_LXOR  = 6'd21;
  localparam logic [5:0] OP_I2L   = 6'd22;
  localparam logic [5:0] OP_L2I   = 6'd23;
  localparam logic [5:0] OP_I2B   = 6'd24;
  localparam logic [5:0] OP_I2C   = 6'd25;
  localparam logic [5:0] OP_I2S   = 6'd26;
  localparam logic [5:0] OP_LCMP  = 6'd27;
  localparam logic [5:0] OP_IFEQ  = 6'd28;
  localparam logic [5:0] OP_IFNE  = 6'd29;
  localparam logic [5:0] OP_IFLT  = 6'd30;
  localparam logic [5:0] OP_IFGE  = 6'd31;
  localparam logic [5:0] OP_IFGT  = 6'd32;
  localparam logic [5:0] OP_IFLE  = 6'd33;
  localparam logic [5:0] OP_ICMPEQ = 6'd34;
  localparam logic [5:0] OP_ICMPNE = 6'd35;
  localparam logic [5:0] OP_ICMPLT = 6'd36;
  localparam logic [5:0] OP_ICMPGE = 6'd37;
  localparam logic [5:0] OP_ICMPGT = 6'd38;
  localparam logic [5:0] OP_ICMPLE = 6'd39;
  localparam logic [5:0] OP_ACMPEQ = 6'd40;
  localparam logic [5:0] OP_ACMPNE = 6'd41;

  // Payload that travels down the divider pipe.
  typedef struct packed {
    logic               div_op;   // idiv/ldiv/irem/lrem
    logic               rem_sel;  // remainder wanted
    logic               w32;      // 32-bit division
    logic               neg_q;
    logic               neg_r;
    logic               dz;
    logic               taken;
    logic [63:0]        res;      // result of every non-divide op
    logic [PC_BITS-1:0] target;
    logic [63:0]        num;      // dividend, quotient bits shift in from the bottom
    logic [63:0]        rem;
    logic [63:0]        den;
  } pipe_t;

  function automatic logic [63:0] sx32(input logic [31:0] x);
    return {{32{x[31]}}, x};
  endfunction

endpackage

`default_nettype wire

// ----- sv/jiab_prep.sv -----
// Front end: decode, simple ops, branch resolve, multiplier partial products,
// divider operand setup. Two register stages. Depends on jiab_pkg.
`default_nettype none

module jiab_prep (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        en,
  input  wire logic                        v_in,
  input  wire logic [5:0]                  op,
  input  wire logic [63:0]                 a,
  input  wire logic [63:0]                 b,
  input  wire logic [jiab_pkg::PC_BITS-1:0] npc,
  input  wire logic [15:0]                 off,
  output logic                             v_out,
  output jiab_pkg::pipe_t                  p_out
);

  jiab_pkg::pipe_t p_next, p1, p2_next;
  logic [63:0] p_ll, p_ll_next;
  logic [31:0] p_lh, p_hl, p_lh_next, p_hl_next;
  logic        is_mul, is_mul_next, mul32, mul32_next, v1;

  always_comb begin
    logic [31:0] a32, b32, shl32, sra32, shr32;
    logic [63:0] da, db, res;
    logic        lt32, eq32, zb, nb, taken, w32;
    a32   = a[31:0];
    b32   = b[31:0];
    shl32 = a32 << b[4:0];
    sra32 = 32'($signed(a32) >>> b[4:0]);
    shr32 = a32 >> b[4:0];
    lt32  = $signed(a32) < $signed(b32);
    eq32  = a32 == b32;
    zb    = b32 == 32'd0;
    nb    = b32[31];
    res   = 64'd0;
    taken = 1'b0;
    unique case (op)
      jiab_pkg::OP_IADD:  res = jiab_pkg::sx32(a32 + b32);
      jiab_pkg::OP_LADD:  res = a + b;
      jiab_pkg::OP_ISUB:  res = jiab_pkg::sx32(a32 - b32);
      jiab_pkg::OP_LSUB:  res = a - b;
      jiab_pkg::OP_ISHL:  res = jiab_pkg::sx32(shl32);
      jiab_pkg::OP_LSHL:  res = a << b[5:0];
      jiab_pkg::OP_ISHR:  res = jiab_pkg::sx32(sra32);
      jiab_pkg::OP_LSHR:  res = 64'($signed(a) >>> b[5:0]);
      jiab_pkg::OP_IUSHR: res = jiab_pkg::sx32(shr32);
      jiab_pkg::OP_LUSHR: res = a >> b[5:0];
      jiab_pkg::OP_IAND:  res = jiab_pkg::sx32(a32 & b32);
      jiab_pkg::OP_LAND:  res = a & b;
      jiab_pkg::OP_IOR:   res = jiab_pkg::sx32(a32 | b32);
      jiab_pkg::OP_LOR:   res = a | b;
      jiab_pkg::OP_IXOR:  res = jiab_pkg::sx32(a32 ^ b32);
      jiab_pkg::OP_LXOR:  res = a ^ b;
      jiab_pkg::OP_I2L,
      jiab_pkg::OP_L2I:   res = jiab_pkg::sx32(b32);
      jiab_pkg::OP_I2B:   res = {{56{b[7]}}, b[7:0]};
      jiab_pkg::OP_I2C:   res = {48'd0, b[15:0]};
      jiab_pkg::OP_I2S:   res = {{48{b[15]}}, b[15:0]};
      jiab_pkg::OP_LCMP:
        res = ($signed(a) > $signed(b)) ? 64'd1 : ((a == b) ? 64'd0 : '1);
      jiab_pkg::OP_IFEQ:   taken = zb;
      jiab_pkg::OP_IFNE:   taken = !zb;
      jiab_pkg::OP_IFLT:   taken = nb;
      jiab_pkg::OP_IFGE:   taken = !nb;
      jiab_pkg::OP_IFGT:   taken = !nb && !zb;
      jiab_pkg::OP_IFLE:   taken = nb || zb;
      jiab_pkg::OP_ICMPEQ: taken = eq32;
      jiab_pkg::OP_ICMPNE: taken = !eq32;
      jiab_pkg::OP_ICMPLT: taken = lt32;
      jiab_pkg::OP_ICMPGE: taken = !lt32;
      jiab_pkg::OP_ICMPGT: taken = !lt32 && !eq32;
      jiab_pkg::OP_ICMPLE: taken = lt32 || eq32;
      jiab_pkg::OP_ACMPEQ: taken = a == b;
      jiab_pkg::OP_ACMPNE: taken = a != b;
      default: ;
    endcase

    w32 = (op == jiab_pkg::OP_IDIV) || (op == jiab_pkg::OP_IREM);
    da  = w32 ? jiab_pkg::sx32(a32) : a;
    db  = w32 ? jiab_pkg::sx32(b32) : b;

    p_next.div_op  = w32 || (op == jiab_pkg::OP_LDIV) || (op == jiab_pkg::OP_LREM);
    p_next.rem_sel = (op == jiab_pkg::OP_IREM) || (op == jiab_pkg::OP_LREM);
    p_next.w32     = w32;
    p_next.neg_q   = da[63] ^ db[63];
    p_next.neg_r   = da[63];
    p_next.dz      = p_next.div_op && (db == 64'd0);
    p_next.taken   = taken;
    p_next.res     = res;
    // offset wraps modulo 2^PC_BITS
    p_next.target  = taken ?
      npc + {{(jiab_pkg::PC_BITS-16){off[15]}}, off} : npc;
    // magnitudes: MIN stays MIN, which reads correctly as unsigned
    p_next.num     = da[63] ? -da : da;
    p_next.den     = db[63] ? -db : db;
    p_next.rem     = 64'd0;

    p_ll_next  = {32'd0, a32} * {32'd0, b32};
    p_lh_next  = a32 * b[63:32];
    p_hl_next  = a[63:32] * b32;
    is_mul_next = (op == jiab_pkg::OP_IMUL) || (op == jiab_pkg::OP_LMUL);
    mul32_next  = op == jiab_pkg::OP_IMUL;
  end

  // second stage: fold the cross products into the product
  always_comb begin
    logic [63:0] prod;
    prod    = p_ll + {p_lh + p_hl, 32'd0};
    p2_next = p1;
    if (is_mul) begin
      p2_next.res = mul32 ? jiab_pkg::sx32(prod[31:0]) : prod;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1    <= 1'b0;
      v_out <= 1'b0;
    end else if (en) begin
      v1    <= v_in;
      v_out <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1     <= p_next;
      p_ll   <= p_ll_next;
      p_lh   <= p_lh_next;
      p_hl   <= p_hl_next;
      is_mul <= is_mul_next;
      mul32  <= mul32_next;
      p_out  <= p2_next;
    end
  end

endmodule

`default_nettype wire

// ----- sv/jiab_div_step.sv -----
// One restoring-division stage: one quotient bit, registered.
// Depends on jiab_pkg.
`default_nettype none

module jiab_div_step (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            en,
  input  wire logic            v_in,
  input  wire jiab_pkg::pipe_t p_in,
  output logic                 v_out,
  output jiab_pkg::pipe_t      p_out
);

  jiab_pkg::pipe_t p_next;

  always_comb begin
    logic [64:0] rs, diff;
    rs     = {p_in.rem, p_in.num[63]};
    diff   = rs - {1'b0, p_in.den};
    p_next = p_in;
    if (!diff[64]) begin
      p_next.rem = diff[63:0];
      p_next.num = {p_in.num[62:0], 1'b1};
    end else begin
      p_next.rem = rs[63:0];
      p_next.num = {p_in.num[62:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_out <= 1'b0;
    end else if (en) begin
      v_out <= v_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_out <= p_next;
    end
  end

endmodule

`default_nettype wire

// ----- sv/jiab_post.sv -----
// Back end: divider sign fix, zero-divisor handling, final select; output register.
// Depends on jiab_pkg.
`default_nettype none

module jiab_post (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         en,
  input  wire logic                         v_in,
  input  wire jiab_pkg::pipe_t              p_in,
  output logic                              v_out,
  output logic [63:0]                       result,
  output logic                              branch_taken,
  output logic [jiab_pkg::PC_BITS-1:0]      target_pc,
  output logic                              div_by_zero
);

  logic [63:0] res_next;

  always_comb begin
    logic [63:0] q, r, val;
    q   = p_in.neg_q ? -p_in.num : p_in.num;
    r   = p_in.neg_r ? -p_in.rem : p_in.rem;
    val = p_in.rem_sel ? r : q;
    if (p_in.w32) begin
      val = jiab_pkg::sx32(val[31:0]);
    end
    if (!p_in.div_op) begin
      res_next = p_in.res;
    end else if (p_in.dz) begin
      res_next = 64'd0;
    end else begin
      res_next = val;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_out <= 1'b0;
    end else if (en) begin
      v_out <= v_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      result       <= res_next;
      branch_taken <= p_in.taken;
      target_pc    <= p_in.target;
      div_by_zero  <= p_in.dz;
    end
  end

endmodule

`default_nettype wire

// ----- sv/jvm_integer_alu_branch.sv -----
// Top level of the JVM integer ALU/branch unit: input register, front end,
// 64-stage divider pipe, back end. Depends on jiab_pkg, jiab_prep, jiab_div_step, jiab_post.
//
//  channel | handshake           | payload
//  in      | in_valid / in_ready | req_type, operand_a, operand_b, next_pc, branch_offset
//  out     | out_valid/out_ready | result, branch_taken, target_pc, div_by_zero
//
// One transfer per cycle in steady state while out_ready is high; every op passes from input
// transfer to result via the input reg, 2 front-end stages, 64 divider stages, output reg.
// The divider's one-bit-per-stage pipe sets the latency.
// The whole pipe advances together: it stalls only while out_valid waits on out_ready.
// Synchronous reset clears all valid bits.
`default_nettype none

module jvm_integer_alu_branch (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [5:0]                   req_type,
  input  wire logic signed [63:0]           operand_a,
  input  wire logic signed [63:0]           operand_b,
  input  wire logic [jiab_pkg::PC_BITS-1:0] next_pc,
  input  wire logic signed [15:0]           branch_offset,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic signed [63:0]                result,
  output logic                              branch_taken,
  output logic [jiab_pkg::PC_BITS-1:0]      target_pc,
  output logic                              div_by_zero
);

  logic                        en, v0;
  logic [5:0]                  op0;
  logic [63:0]                 a0, b0;
  logic [jiab_pkg::PC_BITS-1:0] npc0;
  logic [15:0]                 off0;
  logic                        dv [0:jiab_pkg::DIV_STEPS];
  jiab_pkg::pipe_t             dp [0:jiab_pkg::DIV_STEPS];

  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (en) begin
      v0 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op0  <= req_type;
      a0   <= operand_a;
      b0   <= operand_b;
      npc0 <= next_pc;
      off0 <= branch_offset;
    end
  end

  jiab_prep u_prep (
    .clk, .rst, .en,
    .v_in (v0), .op (op0), .a (a0), .b (b0), .npc (npc0), .off (off0),
    .v_out (dv[0]), .p_out (dp[0])
  );

  for (genvar i = 0; i < jiab_pkg::DIV_STEPS; i++) begin : g_div
    jiab_div_step u_step (
      .clk, .rst, .en,
      .v_in (dv[i]), .p_in (dp[i]),
      .v_out (dv[i+1]), .p_out (dp[i+1])
    );
  end

  jiab_post u_post (
    .clk, .rst, .en,
    .v_in (dv[jiab_pkg::DIV_STEPS]), .p_in (dp[jiab_pkg::DIV_STEPS]),
    .v_out (out_valid), .result (result), .branch_taken (branch_taken),
    .target_pc (target_pc), .div_by_zero (div_by_zero)
  );

  a_dz_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && div_by_zero |-> result == 64'd0)
    else $error("zero divisor with nonzero result");

  a_branch_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && branch_taken |-> !div_by_zero && result == 64'd0)
    else $error("taken branch carries arithmetic result");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("output valid right after reset");

endmodule

`default_nettype wire
